FILE: rtl/far_pkg.sv
package far_pkg;

   localparam int ADDR_BITS  = 24;
   localparam int FieldBits  = 24;
   localparam int KeyBits    = 24;
   localparam int IndexBits  = 2;
   localparam int LoBits     = ADDR_BITS / 2;
   localparam int HiBits     = ADDR_BITS - LoBits;
   localparam int WideBits   = (ADDR_BITS > FieldBits) ? ADDR_BITS : FieldBits;

   typedef logic [FieldBits-1:0] field_type;
   typedef logic [KeyBits-1:0]   key_type;
   typedef logic [IndexBits-1:0] index_type;
   typedef logic [LoBits-1:0]    lo_type;
   typedef logic [HiBits-1:0]    hi_type;

   typedef enum logic [IndexBits-1:0] {
      CSR_KEY_ONE   = 2'd0,
      CSR_KEY_TWO   = 2'd1,
      CSR_KEY_THREE = 2'd2
   } csr_index_type;

   typedef enum logic {
      MIX_HIGH = 1'b0,
      MIX_LOW  = 1'b1
   } mix_type;

   // low half on top: the packed layout is the output word
   typedef struct packed {
      lo_type lo;
      hi_type hi;
   } state_type;

   typedef struct packed {
      key_type one;
      key_type two;
      key_type three;
   } keys_type;

   function automatic hi_type round_hi(lo_type a, key_type k);
      hi_type t;
      t = hi_type'(a) ^ k[HiBits-1:0];
      return hi_type'(t * t);
   endfunction

   function automatic lo_type round_lo(hi_type a, key_type k);
      lo_type t;
      t = a[LoBits-1:0] ^ k[LoBits-1:0];
      return lo_type'(t * t);
   endfunction

   function automatic state_type to_state(field_type f);
      logic [WideBits-1:0] w;
      state_type s;
      w = WideBits'(f);
      s.lo = w[LoBits-1:0];
      s.hi = w[ADDR_BITS-1:LoBits];
      return s;
   endfunction

   function automatic field_type to_field(state_type s);
      logic [WideBits-1:0] w;
      w = WideBits'(s);
      return w[FieldBits-1:0];
   endfunction

endpackage

FILE: rtl/far_if.sv
interface far_req_if import far_pkg::*; ;
   logic      valid;
   logic      ready;
   field_type logical_address;

   modport source (output valid, output logical_address, input ready);
   modport sink   (input valid, input logical_address, output ready);
endinterface

interface far_rsp_if import far_pkg::*; ;
   logic      valid;
   logic      ready;
   field_type mapped_address;

   modport source (output valid, output mapped_address, input ready);
   modport sink   (input valid, input mapped_address, output ready);
endinterface

interface far_csr_if import far_pkg::*; ;
   logic      valid;
   logic      ready;
   index_type index;
   key_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/far_csr.sv
module far_csr import far_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   input  index_type wr_index,
   input  key_type   wr_data,
   output logic      wr_ready,
   output keys_type  keys
);

   keys_type keys_ff, keys_in;

   always_comb begin
      keys_in = keys_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_KEY_ONE:   keys_in.one   = wr_data;
            CSR_KEY_TWO:   keys_in.two   = wr_data;
            CSR_KEY_THREE: keys_in.three = wr_data;
            default:       keys_in       = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign wr_ready = 1'b1;
   assign keys     = keys_ff;

endmodule

FILE: rtl/far_stage.sv
module far_stage import far_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  mix_type   mix,
   input  key_type   key,
   input  logic      in_valid,
   output logic      in_ready,
   input  state_type in_state,
   output logic      out_valid,
   input  logic      out_ready,
   output state_type out_state
);

   logic      valid_ff, valid_in;
   state_type state_ff, state_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      state_in = in_state;
      unique case (mix)
         MIX_HIGH: state_in.hi = in_state.hi ^ round_hi(in_state.lo, key);
         MIX_LOW:  state_in.lo = in_state.lo ^ round_lo(in_state.hi, key);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // advance payload only on a transfer into this stage
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

FILE: rtl/feistel_line_address_randomizer.sv
// Line address randomizer: three-round keyed Feistel permutation.
// req_if  : logical_address in; a transfer is valid && ready at a clock edge.
// rsp_if  : mapped_address out, one result per request, in request order.
// csr_if  : writes round keys; index 0, 1, 2 select keys one, two, three,
//           other indexes are dropped. Always ready. Write only while idle.
// Each round is one register stage (xor, 12x12 square, xor). rsp_if.valid
// rises once the request has passed the round one, two and three registers,
// in that order. One address enters per cycle while rsp_if does not stall;
// sustained throughput is one address per cycle while rsp_if.ready is high.
// A stall on rsp_if holds the last stage; earlier stages keep filling
// until all three are full, then req_if.ready drops in the same cycle.
// Bubbles collapse, so no item is lost or repeated.
// Reset clears all stage valid bits and sets all keys to zero.
module feistel_line_address_randomizer import far_pkg::*; (
   input logic        clock,
   input logic        reset,
   far_req_if.sink    req_if,
   far_rsp_if.source  rsp_if,
   far_csr_if.sink    csr_if
);

   keys_type  keys;
   logic      v1, v2, v3;
   logic      rdy2, rdy3;
   state_type st1, st2, st3;

   far_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .wr_ready (csr_if.ready),
      .keys     (keys)
   );

   far_stage u_round_one (
      .clock     (clock),
      .reset     (reset),
      .mix       (MIX_HIGH),
      .key       (keys.one),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_state  (to_state(req_if.logical_address)),
      .out_valid (v1),
      .out_ready (rdy2),
      .out_state (st1)
   );

   far_stage u_round_two (
      .clock     (clock),
      .reset     (reset),
      .mix       (MIX_LOW),
      .key       (keys.two),
      .in_valid  (v1),
      .in_ready  (rdy2),
      .in_state  (st1),
      .out_valid (v2),
      .out_ready (rdy3),
      .out_state (st2)
   );

   far_stage u_round_three (
      .clock     (clock),
      .reset     (reset),
      .mix       (MIX_HIGH),
      .key       (keys.three),
      .in_valid  (v2),
      .in_ready  (rdy3),
      .in_state  (st2),
      .out_valid (v3),
      .out_ready (rsp_if.ready),
      .out_state (st3)
   );

   assign rsp_if.valid          = v3;
   assign rsp_if.mapped_address = to_field(st3);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !v1 && !v2 && !v3)
      else $error("pipeline not empty after reset");

   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> v1 && v2 && v3 && !rsp_if.ready)
      else $error("request stalled with a free stage");

   a_stage_one_holds: assert property (@(posedge clock) disable iff (reset)
      v1 && !rdy2 |=> v1 && $stable(st1))
      else $error("first stage lost or changed a held item");

   a_stage_two_holds: assert property (@(posedge clock) disable iff (reset)
      v2 && !rdy3 |=> v2 && $stable(st2))
      else $error("second stage lost or changed a held item");

endmodule
